// File: hdl/banked_memory_paging_unit_macros.svh
// Assertion macros shared by the paging unit RTL.
// Every macro samples on the rising edge of clk and is disabled while rst_n is low.
`ifndef BANKED_MEMORY_PAGING_UNIT_MACROS_SVH
`define BANKED_MEMORY_PAGING_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BMPU_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("paging unit check failed in the same cycle");

// The consequent must hold in the cycle after the antecedent.
`define BMPU_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("paging unit check failed in the following cycle");

`endif

// File: hdl/bmpu_pkg.sv
`default_nettype none

package bmpu_pkg;

    // Machine models selected by the configuration register.
    localparam logic [1:0] MODEL_48K      = 2'd0;
    localparam logic [1:0] MODEL_128K     = 2'd1;
    localparam logic [1:0] MODEL_PENTAGON = 2'd2;
    localparam logic [1:0] MODEL_PLUS3    = 2'd3;
    localparam logic [1:0] MODEL_RESET    = MODEL_128K;

    // Access kinds.
    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_READ  = 1'b1;

    // Partial port decoding masks and match values.
    localparam logic [15:0] MASK_CLASSIC     = 16'h8002;
    localparam logic [15:0] MASK_PLUS3_PRI   = 16'hC002;
    localparam logic [15:0] MATCH_PLUS3_PRI  = 16'h4000;
    localparam logic [15:0] MASK_PLUS3_EXT   = 16'hF002;
    localparam logic [15:0] MATCH_PLUS3_EXT  = 16'h1000;

    // Page codes: RAM banks 0 to 7, ROMs from 8 up.
    localparam logic [1:0] PAGE_ROM_PREFIX = 2'b10;
    localparam logic [3:0] PAGE_RAM0       = 4'd0;
    localparam logic [3:0] PAGE_RAM2       = 4'd2;
    localparam logic [3:0] PAGE_RAM5       = 4'd5;
    localparam logic [3:0] PAGE_ROM0       = 4'd8;
    localparam logic [3:0] PAGE_MAX        = 4'd11;
    localparam logic [3:0] CONT_NORMAL     = 4'b0010;

    typedef struct packed {
        logic            kind;
        logic [15:0]     addr;
        logic [7:0]      data;
    } access_t;

    typedef struct packed {
        logic            lock;
        logic [2:0]      ram_bank;
        logic [1:0]      rom_latch;
        logic [1:0]      rom_in_use;
        logic            screen;
        logic            special;
        logic [7:0]      last_primary;
        logic [7:0]      last_extra;
        logic [3:0][3:0] page;
        logic [3:0]      cont;
    } page_state_t;

    typedef struct packed {
        logic [3:0][3:0] page;
        logic [3:0]      cont;
        logic            screen;
        logic            lock;
        logic            all_ram;
    } page_result_t;

    localparam page_state_t STATE_RESET = '{
        lock:         1'b0,
        ram_bank:     3'd0,
        rom_latch:    2'd0,
        rom_in_use:   2'd0,
        screen:       1'b0,
        special:      1'b0,
        last_primary: 8'd0,
        last_extra:   8'd0,
        page:         {PAGE_RAM0, PAGE_RAM2, PAGE_RAM5, PAGE_ROM0},
        cont:         CONT_NORMAL
    };

    // Page mapped into a slot by the +2A/+3 all-RAM configurations.
    function automatic logic [3:0] allram_page(input logic [1:0] cfg, input logic [1:0] slot);
        logic [3:0] pg;
        case ({cfg, slot})
            4'b00_00: pg = 4'd0;
            4'b00_01: pg = 4'd1;
            4'b00_10: pg = 4'd2;
            4'b00_11: pg = 4'd3;
            4'b01_00: pg = 4'd4;
            4'b01_01: pg = 4'd5;
            4'b01_10: pg = 4'd6;
            4'b01_11: pg = 4'd7;
            4'b10_00: pg = 4'd4;
            4'b10_01: pg = 4'd5;
            4'b10_10: pg = 4'd6;
            4'b10_11: pg = 4'd3;
            4'b11_00: pg = 4'd4;
            4'b11_01: pg = 4'd7;
            4'b11_10: pg = 4'd6;
            default:  pg = 4'd3;
        endcase
        return pg;
    endfunction

    // Contention mask of the all-RAM configurations.
    function automatic logic [3:0] allram_cont(input logic [1:0] cfg);
        logic [3:0] m;
        case (cfg)
            2'd0:    m = 4'h0;
            2'd1:    m = 4'hF;
            default: m = 4'h7;
        endcase
        return m;
    endfunction

endpackage

`default_nettype wire

// File: hdl/bmpu_core.sv
`default_nettype none

// Next-state and result logic for one I/O access.
module bmpu_core (
    input  wire bmpu_pkg::access_t      acc,
    input  wire logic [1:0]             model,
    input  wire bmpu_pkg::page_state_t  state_cur,
    output bmpu_pkg::page_state_t       state_new,
    output bmpu_pkg::page_result_t      result
);

    logic hit_classic_wr;
    logic hit_classic_rd;
    logic hit_plus3_pri;
    logic hit_plus3_ext;
    logic is_pentagon;
    logic [7:0] d;
    logic [1:0] cfg;
    logic [1:0] rom_sel;

    assign d           = acc.data;
    assign cfg         = acc.data[2:1];
    assign is_pentagon = (model == bmpu_pkg::MODEL_PENTAGON);

    assign hit_classic_wr = (acc.kind == bmpu_pkg::KIND_WRITE)
                          && ((model == bmpu_pkg::MODEL_128K) || is_pentagon)
                          && ((acc.addr & bmpu_pkg::MASK_CLASSIC) == 16'h0000);
    assign hit_classic_rd = (acc.kind == bmpu_pkg::KIND_READ)
                          && (model == bmpu_pkg::MODEL_128K)
                          && acc.addr[0]
                          && ((acc.addr & bmpu_pkg::MASK_CLASSIC) == 16'h0000);
    assign hit_plus3_pri  = (acc.kind == bmpu_pkg::KIND_WRITE)
                          && (model == bmpu_pkg::MODEL_PLUS3)
                          && ((acc.addr & bmpu_pkg::MASK_PLUS3_PRI) == bmpu_pkg::MATCH_PLUS3_PRI);
    assign hit_plus3_ext  = (acc.kind == bmpu_pkg::KIND_WRITE)
                          && (model == bmpu_pkg::MODEL_PLUS3)
                          && ((acc.addr & bmpu_pkg::MASK_PLUS3_EXT) == bmpu_pkg::MATCH_PLUS3_EXT);

    always_comb begin
        state_new = state_cur;
        rom_sel   = 2'd0;
        if (hit_classic_wr || hit_classic_rd) begin
            if (!state_cur.lock) begin
                rom_sel                = {state_cur.rom_in_use[1], d[4]};
                state_new.lock         = d[5];
                state_new.ram_bank     = d[2:0];
                state_new.page[3]      = {1'b0, d[2:0]};
                state_new.cont[3]      = is_pentagon ? 1'b0 : d[0];
                state_new.rom_latch    = {1'b0, d[4]};
                state_new.rom_in_use   = rom_sel;
                state_new.page[0]      = {bmpu_pkg::PAGE_ROM_PREFIX, rom_sel};
                state_new.screen       = d[3];
            end
            // A floating-bus read pages but is not recorded as a write.
            if (hit_classic_wr) begin
                state_new.last_primary = d;
            end
        end else if (hit_plus3_pri) begin
            if (!state_cur.lock) begin
                rom_sel                = {state_cur.last_extra[2], d[4]};
                state_new.lock         = d[5];
                state_new.rom_latch    = rom_sel;
                state_new.rom_in_use   = rom_sel;
                state_new.ram_bank     = d[2:0];
                if (!state_cur.special) begin
                    state_new.page[0]  = {bmpu_pkg::PAGE_ROM_PREFIX, rom_sel};
                    state_new.cont[0]  = 1'b0;
                    state_new.page[3]  = {1'b0, d[2:0]};
                    state_new.cont[3]  = d[2];
                end
                state_new.screen       = d[3];
            end
            state_new.last_primary     = d;
        end else if (hit_plus3_ext) begin
            if (!state_cur.lock) begin
                if (!d[0]) begin
                    rom_sel              = {d[2], state_cur.last_primary[4]};
                    state_new.special    = 1'b0;
                    state_new.rom_latch  = rom_sel;
                    state_new.rom_in_use = rom_sel;
                    state_new.page[0]    = {bmpu_pkg::PAGE_ROM_PREFIX, rom_sel};
                    state_new.page[1]    = bmpu_pkg::PAGE_RAM5;
                    state_new.page[2]    = bmpu_pkg::PAGE_RAM2;
                    state_new.page[3]    = {1'b0, state_cur.ram_bank};
                    state_new.cont       = bmpu_pkg::CONT_NORMAL
                                         | {state_cur.ram_bank[2], 3'b000};
                end else begin
                    state_new.special    = 1'b1;
                    for (int i = 0; i < 4; i++) begin
                        state_new.page[i] = bmpu_pkg::allram_page(cfg, 2'(i));
                    end
                    state_new.cont       = bmpu_pkg::allram_cont(cfg);
                end
            end
            state_new.last_extra       = d;
        end
    end

    always_comb begin
        result.page    = state_new.page;
        result.cont    = is_pentagon ? 4'b0000 : state_new.cont;
        result.screen  = state_new.screen;
        result.lock    = state_new.lock;
        result.all_ram = state_new.special;
    end

endmodule

`default_nettype wire

// File: hdl/banked_memory_paging_unit.sv
// A word accepted on the input stream is registered in the access stage, then in the
// result stage, from which it is offered on the output stream.
// Throughput: one access per cycle unless the output stalls; the decode is combinational.
// Reset (rst_n low, asynchronous): ROM 0, RAM 5, RAM 2, RAM 0 mapped, slot 1 contended,
// all latches and the lock cleared, machine model set to 128K; both stages empty.
`default_nettype none

`include "banked_memory_paging_unit_macros.svh"

module banked_memory_paging_unit (
    input  wire logic        clk,
    input  wire logic        rst_n,

    // Configuration write channel: the machine model register.
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_data,

    // Input stream, one I/O access per word.
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // tdata fields from bit 0 up: port_address[15:0], bus_data[23:16].
    input  wire logic [23:0] s_axis_tdata,
    // tuser fields from bit 0 up: kind[0].
    input  wire logic        s_axis_tuser,

    // Output stream, one mapping report per access.
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // tdata fields from bit 0 up: slot0_page[3:0], slot1_page[7:4], slot2_page[11:8],
    // slot3_page[15:12], contended_slots[19:16], screen_from_bank_seven[20],
    // paging_locked[21], all_ram_active[22], zero fill[23].
    output logic [23:0]      m_axis_tdata
);

    // The user must write the register only while idle; the block does not enforce this.
    logic [1:0]              model_reg;

    // Access stage.
    logic                    in_valid_reg;
    bmpu_pkg::access_t       in_acc_reg;

    // Paging state, updated when an access moves into the result stage.
    bmpu_pkg::page_state_t   state_reg;
    bmpu_pkg::page_state_t   state_next;

    // Result stage.
    logic                    out_valid_reg;
    bmpu_pkg::page_result_t  out_res_reg;
    bmpu_pkg::page_result_t  res_next;

    logic                    advance;
    logic                    in_take;

    assign cfg_ready     = 1'b1;

    // The access stage empties into the result stage whenever that stage is free or
    // being drained, so a full access stage still takes a new word in the same cycle.
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign in_take       = s_axis_tvalid && s_axis_tready;

    bmpu_core u_core (
        .acc       (in_acc_reg),
        .model     (model_reg),
        .state_cur (state_reg),
        .state_new (state_next),
        .result    (res_next)
    );

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            model_reg <= bmpu_pkg::MODEL_RESET;
        end else if (cfg_valid && cfg_ready) begin
            model_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            in_valid_reg <= 1'b0;
        end else if (in_take) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk) begin
        if (in_take) begin
            in_acc_reg.kind <= s_axis_tuser;
            in_acc_reg.addr <= s_axis_tdata[15:0];
            in_acc_reg.data <= s_axis_tdata[23:16];
        end
    end

    // The paging state is control state and takes its documented reset mapping.
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg <= bmpu_pkg::STATE_RESET;
        end else if (advance) begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_axis_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk) begin
        if (advance) begin
            out_res_reg <= res_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {1'b0,
                            out_res_reg.all_ram,
                            out_res_reg.lock,
                            out_res_reg.screen,
                            out_res_reg.cont,
                            out_res_reg.page[3],
                            out_res_reg.page[2],
                            out_res_reg.page[1],
                            out_res_reg.page[0]};

    // Once set, the lock bit is only cleared by reset.
    `BMPU_ASSERT_NEXT(a_lock_sticky, state_reg.lock, state_reg.lock)
    // The 48K model never changes the paging state.
    `BMPU_ASSERT_NEXT(a_48k_frozen, advance && (model_reg == bmpu_pkg::MODEL_48K), $stable(state_reg))
    // The Pentagon reports no contended slots.
    `BMPU_ASSERT_NOW(a_pentagon_uncontended,
        out_valid_reg && (model_reg == bmpu_pkg::MODEL_PENTAGON), m_axis_tdata[19:16] == 4'b0000)
    // With both stages full and the output stalled, no new word may enter.
    `BMPU_ASSERT_NOW(a_full_backpressure,
        in_valid_reg && out_valid_reg && !m_axis_tready, !s_axis_tready)
    // Slot 0 always holds a valid page code.
    `BMPU_ASSERT_NOW(a_slot0_range, 1'b1, state_reg.page[0] <= bmpu_pkg::PAGE_MAX)

endmodule

`default_nettype wire

// File: tb/banked_memory_paging_unit_tb.sv
`timescale 1ns / 1ps

module banked_memory_paging_unit_tb;

    // One mapping report, laid out as the output tdata from bit 22 down to bit 0.
    typedef struct packed {
        logic       all_ram;
        logic       locked;
        logic       screen7;
        logic [3:0] contended;
        logic [3:0] slot3;
        logic [3:0] slot2;
        logic [3:0] slot1;
        logic [3:0] slot0;
    } paging_report_t;

    logic        clk;
    logic        rst_n = 1'b0;

    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_data = bmpu_pkg::MODEL_RESET;

    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    // tdata fields from bit 0 up: port_address[15:0], bus_data[23:16].
    logic [23:0] s_axis_tdata = '0;
    // tuser fields from bit 0 up: kind[0].
    logic        s_axis_tuser = bmpu_pkg::KIND_WRITE;

    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    // tdata fields from bit 0 up: slot0..slot3 pages, contended_slots, screen_from_bank_seven,
    // paging_locked, all_ram_active, zero fill[23].
    logic [23:0] m_axis_tdata;

    banked_memory_paging_unit uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // Accesses waiting for the driver, and reports waiting for the output stream.
    bmpu_pkg::access_t pending_accesses[$];
    paging_report_t    expected_reports[$];
    logic [1:0]        model_requests[$];

    bmpu_pkg::access_t word_on_bus;
    int unsigned tx_idle_pct = 10;
    int unsigned rx_idle_pct = 61;
    int unsigned queued_words = 0;
    int unsigned accepted_words = 0;
    int unsigned checked_words = 0;
    int unsigned model_writes = 0;
    int unsigned mismatches = 0;

    // Predicted copy of the paging latches. Only state that can reach the outputs is kept;
    // the ROM select latch always equals the ROM page in use where it is visible.
    logic [1:0]      model_sel;
    logic            pg_locked;
    logic [2:0]      ram_bank;
    logic [1:0]      rom_in_use;
    logic            screen_hi;
    logic            ram_only;
    logic [7:0]      last_primary;
    logic [7:0]      last_extra;
    logic [3:0][3:0] slot_map;
    logic [3:0]      contention;

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    task automatic reset_prediction();
        model_sel    = bmpu_pkg::MODEL_RESET;
        pg_locked    = 1'b0;
        ram_bank     = 3'd0;
        rom_in_use   = 2'd0;
        screen_hi    = 1'b0;
        ram_only     = 1'b0;
        last_primary = 8'h00;
        last_extra   = 8'h00;
        slot_map     = {bmpu_pkg::PAGE_RAM0, bmpu_pkg::PAGE_RAM2, bmpu_pkg::PAGE_RAM5,
                        bmpu_pkg::PAGE_ROM0};
        contention   = bmpu_pkg::CONT_NORMAL;
    endtask

    // Slot pages of the four all-RAM layouts, slot 3 in the top nibble.
    function automatic logic [15:0] ram_only_slots(input logic [1:0] layout);
        case (layout)
            2'd0:    return 16'h3210;
            2'd1:    return 16'h7654;
            2'd2:    return 16'h3654;
            default: return 16'h3674;
        endcase
    endfunction

    // Primary port on the 128K and the Pentagon. Bit 1 of the ROM page survives the write.
    task automatic page_classic(input logic [7:0] d, input logic pentagon);
        if (!pg_locked)
        begin
            pg_locked     = d[5];
            ram_bank      = d[2:0];
            slot_map[3]   = {1'b0, ram_bank};
            contention[3] = pentagon ? 1'b0 : ram_bank[0];
            rom_in_use    = {rom_in_use[1], d[4]};
            slot_map[0]   = {bmpu_pkg::PAGE_ROM_PREFIX, rom_in_use};
            screen_hi     = d[3];
        end
    endtask

    // Primary port on the +2A/+3. In all-RAM mode only the latches move.
    task automatic page_plus3_primary(input logic [7:0] d);
        if (!pg_locked)
        begin
            pg_locked  = d[5];
            rom_in_use = {last_extra[2], d[4]};
            ram_bank   = d[2:0];
            if (!ram_only)
            begin
                slot_map[0]   = {bmpu_pkg::PAGE_ROM_PREFIX, rom_in_use};
                contention[0] = 1'b0;
                slot_map[3]   = {1'b0, ram_bank};
                contention[3] = ram_bank[2];
            end
            screen_hi = d[3];
        end
        last_primary = d;
    endtask

    // Extra port on the +2A/+3: bit 0 selects all-RAM mode, bits 2:1 its layout.
    task automatic page_plus3_extra(input logic [7:0] d);
        if (!pg_locked)
        begin
            if (!d[0])
            begin
                ram_only   = 1'b0;
                rom_in_use = {d[2], last_primary[4]};
                slot_map   = {{1'b0, ram_bank}, bmpu_pkg::PAGE_RAM2, bmpu_pkg::PAGE_RAM5,
                              {bmpu_pkg::PAGE_ROM_PREFIX, rom_in_use}};
                contention = bmpu_pkg::CONT_NORMAL | {ram_bank[2], 3'b000};
            end
            else
            begin
                ram_only = 1'b1;
                slot_map = ram_only_slots(d[2:1]);
                case (d[2:1])
                    2'd0:    contention = 4'h0;
                    2'd1:    contention = 4'hF;
                    default: contention = 4'h7;
                endcase
            end
        end
        last_extra = d;
    endtask

    task automatic apply_access(input bmpu_pkg::access_t acc);
        if (acc.kind == bmpu_pkg::KIND_WRITE)
        begin
            if ((model_sel == bmpu_pkg::MODEL_128K || model_sel == bmpu_pkg::MODEL_PENTAGON)
                && (acc.addr & bmpu_pkg::MASK_CLASSIC) == 16'h0000)
            begin
                page_classic(acc.data, model_sel == bmpu_pkg::MODEL_PENTAGON);
                last_primary = acc.data;
            end
            else if (model_sel == bmpu_pkg::MODEL_PLUS3
                     && (acc.addr & bmpu_pkg::MASK_PLUS3_PRI) == bmpu_pkg::MATCH_PLUS3_PRI)
                page_plus3_primary(acc.data);
            else if (model_sel == bmpu_pkg::MODEL_PLUS3
                     && (acc.addr & bmpu_pkg::MASK_PLUS3_EXT) == bmpu_pkg::MATCH_PLUS3_EXT)
                page_plus3_extra(acc.data);
        end
        else if (model_sel == bmpu_pkg::MODEL_128K && acc.addr[0]
                 && (acc.addr & bmpu_pkg::MASK_CLASSIC) == 16'h0000)
        begin
            // A 128K read of the paging port latches the floating bus byte.
            page_classic(acc.data, 1'b0);
        end
    endtask

    function automatic paging_report_t current_report();
        paging_report_t r;
        r.slot0     = slot_map[0];
        r.slot1     = slot_map[1];
        r.slot2     = slot_map[2];
        r.slot3     = slot_map[3];
        // The Pentagon has no contended memory at all.
        r.contended = (model_sel == bmpu_pkg::MODEL_PENTAGON) ? 4'h0 : contention;
        r.screen7   = screen_hi;
        r.locked    = pg_locked;
        r.all_ram   = ram_only;
        return r;
    endfunction

    // Configuration channel: one model write at a time, taken from the request queue.
    always @(posedge clk)
    begin
        if (cfg_valid && cfg_ready)
        begin
            model_sel = cfg_data;
            model_writes++;
        end
        if (!cfg_valid || cfg_ready)
        begin
            if (model_requests.size() != 0)
            begin
                cfg_valid <= 1'b1;
                cfg_data  <= model_requests.pop_front();
            end
            else
                cfg_valid <= 1'b0;
        end
    end

    // Input driver. The prediction is made at the edge where the word is accepted.
    always @(posedge clk)
    begin
        if (!rst_n)
            s_axis_tvalid <= 1'b0;
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                apply_access(word_on_bus);
                expected_reports.push_back(current_report());
                accepted_words++;
            end
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (pending_accesses.size() != 0 && $urandom_range(99) >= tx_idle_pct)
                begin
                    word_on_bus = pending_accesses.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= {word_on_bus.data, word_on_bus.addr};
                    s_axis_tuser  <= word_on_bus.kind;
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    task automatic report_mismatch(input string what, input paging_report_t want,
                                   input paging_report_t seen);
        mismatches++;
        if (mismatches <= 10)
            $display("[%0t] %s: expected slots %h %h %h %h cont %h scr %b lock %b allram %b,",
                     $realtime, what, want.slot0, want.slot1, want.slot2, want.slot3,
                     want.contended, want.screen7, want.locked, want.all_ram,
                     " got slots %h %h %h %h cont %h scr %b lock %b allram %b fill %b",
                     seen.slot0, seen.slot1, seen.slot2, seen.slot3, seen.contended,
                     seen.screen7, seen.locked, seen.all_ram, m_axis_tdata[23]);
    endtask

    // Output monitor with a randomly stalling ready.
    always @(posedge clk)
    begin : monitor
        paging_report_t seen;
        paging_report_t want;
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                seen = paging_report_t'(m_axis_tdata[22:0]);
                if (expected_reports.size() == 0)
                    report_mismatch("report with no access behind it", '0, seen);
                else
                begin
                    want = expected_reports.pop_front();
                    checked_words++;
                    if (seen.slot0 !== want.slot0 || seen.slot1 !== want.slot1
                        || seen.slot2 !== want.slot2 || seen.slot3 !== want.slot3
                        || seen.contended !== want.contended || seen.screen7 !== want.screen7
                        || seen.locked !== want.locked || seen.all_ram !== want.all_ram
                        || m_axis_tdata[23] !== 1'b0)
                        report_mismatch("report mismatch", want, seen);
                end
            end
        end
        m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
    end

    task automatic queue_access(input logic kind, input logic [15:0] addr,
                                input logic [7:0] data);
        bmpu_pkg::access_t acc;
        acc.kind = kind;
        acc.addr = addr;
        acc.data = data;
        pending_accesses.push_back(acc);
        queued_words++;
    endtask

    // Random access weighted toward the paging ports. Unless locking is allowed, bit 5 is
    // cleared on anything that could decode as a primary port, since the lock only clears
    // at reset.
    task automatic queue_random_access(input bit allow_lock);
        logic        kind;
        logic [15:0] addr;
        logic [7:0]  data;
        int unsigned pick;
        pick = $urandom_range(99);
        kind = ($urandom_range(99) < 30) ? bmpu_pkg::KIND_READ : bmpu_pkg::KIND_WRITE;
        addr = 16'($urandom);
        data = 8'($urandom);
        if (pick < 30)
            addr = addr & ~bmpu_pkg::MASK_CLASSIC;
        else if (pick < 55)
            addr = (addr & ~bmpu_pkg::MASK_PLUS3_PRI) | bmpu_pkg::MATCH_PLUS3_PRI;
        else if (pick < 80)
            addr = (addr & ~bmpu_pkg::MASK_PLUS3_EXT) | bmpu_pkg::MATCH_PLUS3_EXT;
        if (!allow_lock
            && ((addr & bmpu_pkg::MASK_CLASSIC) == 16'h0000
                || (addr & bmpu_pkg::MASK_PLUS3_PRI) == bmpu_pkg::MATCH_PLUS3_PRI))
            data[5] = 1'b0;
        queue_access(kind, addr, data);
    endtask

    // Wait until every queued word has been reported, then let the pipeline drain.
    task automatic settle();
        while (accepted_words != queued_words || checked_words != accepted_words)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_model(input logic [1:0] m);
        int unsigned target;
        target = model_writes + 1;
        model_requests.push_back(m);
        while (model_writes < target)
            @(posedge clk);
    endtask

    initial
    begin : stimulus
        logic [1:0] phase_models [9];
        phase_models = '{bmpu_pkg::MODEL_PLUS3, bmpu_pkg::MODEL_128K, bmpu_pkg::MODEL_PENTAGON,
                         bmpu_pkg::MODEL_48K, bmpu_pkg::MODEL_PLUS3, bmpu_pkg::MODEL_128K,
                         bmpu_pkg::MODEL_PLUS3, bmpu_pkg::MODEL_PENTAGON,
                         bmpu_pkg::MODEL_PLUS3};
        reset_prediction();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part, starting on the reset model (128K).
        queue_access(bmpu_pkg::KIND_WRITE, 16'h7FFD, 8'h17);
        queue_access(bmpu_pkg::KIND_WRITE, 16'h7FFD, 8'h08);
        queue_access(bmpu_pkg::KIND_READ,  16'h7FFD, 8'h13);  // floating bus byte pages
        queue_access(bmpu_pkg::KIND_READ,  16'h7FFC, 8'h05);  // bit 0 clear: no paging
        queue_access(bmpu_pkg::KIND_WRITE, 16'hFFFD, 8'h07);  // bit 15 set: not the port
        queue_access(bmpu_pkg::KIND_WRITE, 16'h0000, 8'hDF);
        queue_access(bmpu_pkg::KIND_READ,  16'hFFFF, 8'hFF);
        queue_access(bmpu_pkg::KIND_WRITE, 16'hFFFF, 8'hFF);
        settle();
        write_model(bmpu_pkg::MODEL_PENTAGON);
        queue_access(bmpu_pkg::KIND_WRITE, 16'h7FFD, 8'h03);  // odd bank, yet nothing contended
        queue_access(bmpu_pkg::KIND_READ,  16'h7FFD, 8'h11);  // Pentagon reads never page
        settle();
        write_model(bmpu_pkg::MODEL_PLUS3);
        queue_access(bmpu_pkg::KIND_WRITE, 16'h1FFD, 8'h01);  // all four all-RAM layouts
        queue_access(bmpu_pkg::KIND_WRITE, 16'h1FFD, 8'h03);
        queue_access(bmpu_pkg::KIND_WRITE, 16'h1FFD, 8'h05);
        queue_access(bmpu_pkg::KIND_WRITE, 16'h1FFD, 8'h07);
        queue_access(bmpu_pkg::KIND_WRITE, 16'h7FFD, 8'h07);  // latches only while in all-RAM mode
        queue_access(bmpu_pkg::KIND_WRITE, 16'h1FFD, 8'h04);  // back to normal paging, ROM bit 1
        queue_access(bmpu_pkg::KIND_WRITE, 16'h7FFD, 8'h15);
        queue_access(bmpu_pkg::KIND_READ,  16'h7FFD, 8'h02);  // +3 reads never page
        queue_access(bmpu_pkg::KIND_WRITE, 16'h4000, 8'h06);
        settle();
        write_model(bmpu_pkg::MODEL_48K);
        queue_access(bmpu_pkg::KIND_WRITE, 16'h7FFD, 8'h27);  // the 48K ignores every port
        queue_access(bmpu_pkg::KIND_WRITE, 16'h1FFD, 8'h01);
        settle();
        write_model(bmpu_pkg::MODEL_128K);
        queue_access(bmpu_pkg::KIND_WRITE, 16'h7FFD, 8'h00);  // rewrites slots left by +3 rules

        // Random phases: sender idles lightly first, then the receiver, then neither.
        for (int p = 0; p < 9; p++)
        begin
            settle();
            if (p == 3)
            begin
                tx_idle_pct = 61;
                rx_idle_pct = 10;
            end
            else if (p == 6)
            begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            write_model(phase_models[p]);
            repeat (90) queue_random_access(1'b0);
        end

        // Lock the paging last, since only reset releases it.
        settle();
        write_model(bmpu_pkg::MODEL_128K);
        queue_access(bmpu_pkg::KIND_WRITE, 16'h7FFD, 8'h20);
        queue_access(bmpu_pkg::KIND_WRITE, 16'h7FFD, 8'h07);  // ignored once locked
        repeat (40) queue_random_access(1'b1);
        settle();
        write_model(bmpu_pkg::MODEL_PLUS3);
        queue_access(bmpu_pkg::KIND_WRITE, 16'h1FFD, 8'h01);  // no all-RAM mode while locked
        repeat (40) queue_random_access(1'b1);
        settle();
        repeat (10) @(posedge clk);

        if (expected_reports.size() != 0)
            mismatches += expected_reports.size();
        $display("Checked %0d mapping reports over %0d machine-model writes,",
                 checked_words, model_writes);
        $display("covering 48K, 128K, Pentagon and +3 rules, all-RAM layouts and paging lock.");
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run of about a thousand words.
    initial
    begin
        #5_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
